[src/curve_point_evaluator_unit_defines.svh]
// Assertion macros shared by the curve evaluator RTL.
`ifndef CURVE_POINT_EVALUATOR_UNIT_DEFINES_SVH
`define CURVE_POINT_EVALUATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define CPE_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("curve evaluator: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CPE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("curve evaluator: next-cycle check failed");

`else

`define CPE_ASSERT_IMPL(name, clk, rst, ante, cons)
`define CPE_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

[src/cpe_pkg.sv]
package cpe_pkg;

  // Width of one multiplier slice of the wide Horner operand.
  localparam int LIMB_WIDTH = 32;

  // Guard bits of a power-basis coefficient above the sample width.
  localparam int COEF_GUARD = 5;

  typedef enum logic [1:0] {
    REQ_LINEAR       = 2'd0,
    REQ_CATMULL_ROM  = 2'd1,
    REQ_QUAD_BEZIER  = 2'd2,
    REQ_CUBIC_BEZIER = 2'd3
  } req_type_t;

endpackage

[src/cpe_req_if.sv]
interface cpe_req_if #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 15
);
  logic                            valid;
  logic                            ready;
  cpe_pkg::req_type_t              req_type;
  logic signed [SAMPLE_WIDTH-1:0]  point_zero;
  logic signed [SAMPLE_WIDTH-1:0]  point_one;
  logic signed [SAMPLE_WIDTH-1:0]  point_two;
  logic signed [SAMPLE_WIDTH-1:0]  point_three;
  logic        [FRACTION_BITS:0]   blend_position;

  modport source (
    output valid, req_type, point_zero, point_one, point_two, point_three,
           blend_position,
    input  ready
  );

  modport sink (
    input  valid, req_type, point_zero, point_one, point_two, point_three,
           blend_position,
    output ready
  );
endinterface

[src/cpe_res_if.sv]
interface cpe_res_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] curve_value;
  logic                           clipped;

  modport source (output valid, curve_value, clipped, input ready);
  modport sink   (input valid, curve_value, clipped, output ready);
endinterface

[src/curve_point_evaluator_unit.sv]
// An accepted request word passes the coefficient, Horner and rounding stages to become its result word on res.
// Throughput: one word per cycle; a stalled res backs up stage by stage, and req stays
// ready while any stage holds a bubble.
// Reset: synchronous, active high; clears every stage valid flag, payload is not reset.
`include "curve_point_evaluator_unit_defines.svh"

module curve_point_evaluator_unit #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 15
) (
  input  logic      clk,
  input  logic      rst,
  cpe_req_if.sink   req,
  cpe_res_if.source res
);

  // The curve is evaluated in Horner form over a shared power basis:
  //   H = ((a*t + b*T)*t + c*T^2)*t + (d + 1/2)*T^3,   T = 2^FRACTION_BITS
  // and the result is H >> (3*FRACTION_BITS + 1), rounded and saturated.
  // Each curve's coefficients are pre-scaled so that one shift serves all.
  localparam int TW  = FRACTION_BITS + 1;
  localparam int CW  = SAMPLE_WIDTH + cpe_pkg::COEF_GUARD;
  localparam int YW1 = CW + FRACTION_BITS + 1;
  localparam int YW2 = CW + 2 * FRACTION_BITS + 2;
  localparam int YW3 = CW + 3 * FRACTION_BITS + 3;
  localparam int PW1 = 2 * CW + TW;
  localparam int PW2 = CW + TW;

  // coefficient stage
  logic                 c_valid;
  logic signed [CW-1:0] c_a, c_b, c_c, c_d;
  logic        [TW-1:0] c_t;

  // Horner steps
  logic                  m1_ready, m1_valid;
  logic signed [YW1-1:0] m1_y;
  logic        [PW1-1:0] m1_pass;
  logic                  m2_ready, m2_valid;
  logic signed [YW2-1:0] m2_y;
  logic        [PW2-1:0] m2_pass;
  logic                  m3_ready, m3_valid;
  logic signed [YW3-1:0] m3_y;
  logic        [TW-1:0]  m3_t;
  logic                  r_ready;

  // Stage 1: clamp t, build the scaled power-basis coefficients.
  cpe_coef #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_coef (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .down_ready (m1_ready),
    .out_valid  (c_valid),
    .coef_a     (c_a),
    .coef_b     (c_b),
    .coef_c     (c_c),
    .coef_d     (c_d),
    .t_out      (c_t)
  );

  // Stages 2-3: a*t + b*T; carry c, d and t along.
  cpe_mac #(
    .X_WIDTH    (CW),
    .K_WIDTH    (CW),
    .SHIFT      (FRACTION_BITS),
    .Y_WIDTH    (YW1),
    .PASS_WIDTH (PW1),
    .T_WIDTH    (TW)
  ) u_mac1 (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (c_valid),
    .up_ready   (m1_ready),
    .x          (c_a),
    .k          (c_b),
    .pass_in    ({c_c, c_d, c_t}),
    .out_valid  (m1_valid),
    .down_ready (m2_ready),
    .y          (m1_y),
    .pass_out   (m1_pass)
  );

  // Stages 4-5: y1*t + c*T^2; carry d and t.
  cpe_mac #(
    .X_WIDTH    (YW1),
    .K_WIDTH    (CW),
    .SHIFT      (2 * FRACTION_BITS),
    .Y_WIDTH    (YW2),
    .PASS_WIDTH (PW2),
    .T_WIDTH    (TW)
  ) u_mac2 (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (m1_valid),
    .up_ready   (m2_ready),
    .x          (m1_y),
    .k          (m1_pass[TW+CW +: CW]),
    .pass_in    (m1_pass[PW2-1:0]),
    .out_valid  (m2_valid),
    .down_ready (m3_ready),
    .y          (m2_y),
    .pass_out   (m2_pass)
  );

  // Stages 6-7: y2*t + (d + 1/2)*T^3; the half is already inside d.
  cpe_mac #(
    .X_WIDTH    (YW2),
    .K_WIDTH    (CW),
    .SHIFT      (3 * FRACTION_BITS),
    .Y_WIDTH    (YW3),
    .PASS_WIDTH (TW),
    .T_WIDTH    (TW)
  ) u_mac3 (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (m2_valid),
    .up_ready   (m3_ready),
    .x          (m2_y),
    .k          (m2_pass[TW +: CW]),
    .pass_in    (m2_pass[TW-1:0]),
    .out_valid  (m3_valid),
    .down_ready (r_ready),
    .y          (m3_y),
    .pass_out   (m3_t)
  );

  // Stage 8: drop the fraction, saturate, flag; this is the output register.
  cpe_round #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .Y_WIDTH       (YW3)
  ) u_round (
    .clk      (clk),
    .rst      (rst),
    .in_valid (m3_valid),
    .up_ready (r_ready),
    .y        (m3_y),
    .res      (res)
  );

  // Input backs up only when every stage is full and the output is stalled.
  `CPE_ASSERT_IMPL(a_stall_source, clk, rst, !req.ready, res.valid && !res.ready)
  // An accepted word always lands in the coefficient stage.
  `CPE_ASSERT_NEXT(a_accept_lands, clk, rst, req.valid && req.ready, c_valid)
  // The position carried down the pipe never exceeds one.
  `CPE_ASSERT_IMPL(a_t_clamped, clk, rst, m3_valid, !m3_t[TW-1] || (m3_t[TW-2:0] == '0))

endmodule

[src/cpe_coef.sv]
module cpe_coef #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 15,
  localparam int CW = SAMPLE_WIDTH + cpe_pkg::COEF_GUARD,
  localparam int TW = FRACTION_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  cpe_req_if.sink              req,
  input  logic                 down_ready,
  output logic                 out_valid,
  output logic signed [CW-1:0] coef_a,
  output logic signed [CW-1:0] coef_b,
  output logic signed [CW-1:0] coef_c,
  output logic signed [CW-1:0] coef_d,
  output logic        [TW-1:0] t_out
);

  localparam logic [TW-1:0]        T_ONE     = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic signed [CW-1:0] HALF_UNIT = CW'(1);

  logic signed [CW-1:0] p0, p1, p2, p3;
  logic signed [CW-1:0] dif10, d12, sec, cub, cr_b;
  logic signed [CW-1:0] a_next, b_next, c_next, d_next;
  logic        [TW-1:0] t_next;
  logic                 en;

  assign en        = !out_valid || down_ready;
  assign req.ready = en;

  // Power-basis coefficients, scaled so every curve shares one final shift.
  always_comb begin
    p0    = CW'(req.point_zero);
    p1    = CW'(req.point_one);
    p2    = CW'(req.point_two);
    p3    = CW'(req.point_three);
    dif10 = p1 - p0;
    d12   = p1 - p2;
    sec   = p0 - (p1 <<< 1) + p2;
    cub   = p3 - p0 + (d12 <<< 1) + d12;
    cr_b  = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
    case (req.req_type)
      cpe_pkg::REQ_CATMULL_ROM: begin
        a_next = cub;
        b_next = cr_b;
        c_next = p2 - p0;
        d_next = (p1 <<< 1) + HALF_UNIT;
      end
      cpe_pkg::REQ_QUAD_BEZIER: begin
        a_next = '0;
        b_next = sec <<< 1;
        c_next = dif10 <<< 2;
        d_next = (p0 <<< 1) + HALF_UNIT;
      end
      cpe_pkg::REQ_CUBIC_BEZIER: begin
        a_next = cub <<< 1;
        b_next = (sec <<< 2) + (sec <<< 1);
        c_next = (dif10 <<< 2) + (dif10 <<< 1);
        d_next = (p0 <<< 1) + HALF_UNIT;
      end
      default: begin
        a_next = '0;
        b_next = '0;
        c_next = dif10 <<< 1;
        d_next = (p0 <<< 1) + HALF_UNIT;
      end
    endcase
    // clamp t to one
    t_next = (req.blend_position > T_ONE) ? T_ONE : req.blend_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && req.valid) begin
      coef_a <= a_next;
      coef_b <= b_next;
      coef_c <= c_next;
      coef_d <= d_next;
      t_out  <= t_next;
    end
  end

endmodule

[src/cpe_mac.sv]
`include "curve_point_evaluator_unit_defines.svh"

module cpe_mac #(
  parameter int X_WIDTH    = 21,
  parameter int K_WIDTH    = 21,
  parameter int SHIFT      = 15,
  parameter int Y_WIDTH    = 37,
  parameter int PASS_WIDTH = 16,
  parameter int T_WIDTH    = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        up_ready,
  input  logic signed [X_WIDTH-1:0]   x,
  input  logic signed [K_WIDTH-1:0]   k,
  input  logic        [PASS_WIDTH-1:0] pass_in,
  output logic                        out_valid,
  input  logic                        down_ready,
  output logic signed [Y_WIDTH-1:0]   y,
  output logic        [PASS_WIDTH-1:0] pass_out
);

  localparam int LW     = cpe_pkg::LIMB_WIDTH;
  localparam int NL     = (X_WIDTH + LW - 1) / LW;
  localparam int XE     = NL * LW;
  localparam int PPW    = LW + T_WIDTH + 1;
  localparam int GW_RAW = (XE + T_WIDTH > K_WIDTH + SHIFT) ? XE + T_WIDTH : K_WIDTH + SHIFT;
  localparam int AW     = GW_RAW + 2;
  localparam int FILL   = AW - XE - T_WIDTH;

  logic signed [XE-1:0]      xe;
  logic signed [LW:0]        mop;
  logic signed [T_WIDTH:0]   top;
  logic signed [PPW-1:0]     pp_next [NL];

  logic                      va;
  logic signed [PPW-1:0]     pp [NL];
  logic signed [K_WIDTH-1:0] ka;
  logic [PASS_WIDTH-1:0]     pass_a;

  logic signed [AW-1:0]      even, odd, kx, sum;
  logic                      en_a, en_b;

  assign en_b     = !out_valid || down_ready;
  assign en_a     = !va || en_b;
  assign up_ready = en_a;

  // Slice the operand and multiply each slice by t; only the top slice is signed.
  always_comb begin
    xe  = XE'(x);
    top = {1'b0, pass_in[T_WIDTH-1:0]};
    mop = '0;
    for (int i = 0; i < NL; i++) begin
      mop        = {((i == NL - 1) ? xe[i*LW + LW - 1] : 1'b0), xe[i*LW +: LW]};
      pp_next[i] = mop * top;
    end
  end

  // Slice products two limbs apart never overlap: pack them into two words.
  always_comb begin
    even = '0;
    odd  = '0;
    for (int i = 0; i < NL; i++) begin
      if ((i % 2) == 0) begin
        even[i*LW +: LW+T_WIDTH] = pp[i][LW+T_WIDTH-1:0];
      end else begin
        odd[i*LW +: LW+T_WIDTH] = pp[i][LW+T_WIDTH-1:0];
      end
    end
    if (((NL - 1) % 2) == 0) begin
      even[AW-1 -: FILL] = {FILL{pp[NL-1][PPW-1]}};
    end else begin
      odd[AW-1 -: FILL] = {FILL{pp[NL-1][PPW-1]}};
    end
    kx  = AW'(ka) <<< SHIFT;
    sum = even + odd + kx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) begin
        va <= in_valid;
      end
      if (en_b) begin
        out_valid <= va;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      pp     <= pp_next;
      ka     <= k;
      pass_a <= pass_in;
    end
    if (en_b && va) begin
      y        <= sum[Y_WIDTH-1:0];
      pass_out <= pass_a;
    end
  end

  `CPE_ASSERT_NEXT(a_mac_hold, clk, rst, out_valid && !down_ready, out_valid && $stable(y))
  `CPE_ASSERT_IMPL(a_mac_bubble, clk, rst, !va, up_ready)

endmodule

[src/cpe_round.sv]
`include "curve_point_evaluator_unit_defines.svh"

module cpe_round #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 15,
  parameter int Y_WIDTH       = 39
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       up_ready,
  input  logic signed [Y_WIDTH-1:0]  y,
  cpe_res_if.source                  res
);

  localparam int SH = 3 * FRACTION_BITS + 1;
  localparam int QW = Y_WIDTH - SH;
  localparam logic [SAMPLE_WIDTH-1:0] MAXV = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] MINV = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [QW-1:0]              q;
  logic [QW-SAMPLE_WIDTH:0]   hi_bits;
  logic                       in_range;
  logic [SAMPLE_WIDTH-1:0]    value_next;

  logic                       out_valid;
  logic [SAMPLE_WIDTH-1:0]    value;
  logic                       clipped;
  logic                       en;

  assign en       = !out_valid || res.ready;
  assign up_ready = en;

  // The half was folded in upstream: dropping the fraction bits rounds.
  always_comb begin
    q          = y[Y_WIDTH-1:SH];
    hi_bits    = q[QW-1:SAMPLE_WIDTH-1];
    in_range   = (&hi_bits) || !(|hi_bits);
    value_next = in_range ? q[SAMPLE_WIDTH-1:0] : (q[QW-1] ? MINV : MAXV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      value   <= value_next;
      clipped <= !in_range;
    end
  end

  assign res.valid       = out_valid;
  assign res.curve_value = value;
  assign res.clipped     = clipped;

  `CPE_ASSERT_IMPL(a_clip_at_rail, clk, rst, out_valid && clipped, value == MAXV || value == MINV)

endmodule
